// ===== rtl/b64d_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package b64d_pkg;

  // Status codes carried on the done item
  localparam logic [2:0] ST_OK             = 3'd0;
  localparam logic [2:0] ST_EXCESS_PAD     = 3'd1;
  localparam logic [2:0] ST_DATA_AFTER_PAD = 3'd2;
  localparam logic [2:0] ST_INVALID        = 3'd3;
  localparam logic [2:0] ST_WHITESPACE     = 3'd4;

  // Symbol classes beyond the 6-bit digit values
  localparam logic [6:0] SYM_INVALID = 7'd64;
  localparam logic [6:0] SYM_SPACE   = 7'd65;

  localparam logic [7:0] CHAR_PAD = 8'h3D;  // '='

  // Configuration register map (index = byte address / 4)
  localparam int unsigned PADDR_W  = 1;
  localparam logic [PADDR_W-1:0] REG_SKIP_WS = 1'b0;

  // Map one text character to its digit value, or to a symbol class.
  function automatic logic [6:0] sym_value(input logic [7:0] c);
    logic [6:0] v;
    v = SYM_INVALID;
    if (c >= 8'h41 && c <= 8'h5A) begin
      v = 7'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      v = 7'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v = 7'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B || c == 8'h2D) begin
      v = 7'd62;
    end else if (c == 8'h2F || c == 8'h5F) begin
      v = 7'd63;
    end else if (c == 8'h20 || c == 8'h0D || c == 8'h09 || c == 8'h0A) begin
      v = SYM_SPACE;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/base64_stream_decoder_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                Payload
// -------   ---------  -----------------------  -----------------------------------------
// input     in         in_valid_i / in_ready_o  char_in_i[7:0], end_of_text_i
// result    out        out_valid_o/out_ready_i  byte_valid_o, data_byte_o[7:0],
//                                               status_o[2:0], done_res_o
// config    in         APB (psel..pready)       skip_whitespace at byte address 0
//
// Cycles: one item per cycle while the output register has room; each item is decoded
//   by one table lookup and a small shift mux, and its result is registered there.
// Reset: rst_ni clears the bit accumulator, pad count, error code, the
//   skip_whitespace register and the output valid flag.
// Stalls: the output register holds one result; a new item is taken whenever
//   that register is empty or is being drained in the same cycle.
// Items that produce no result (whitespace skips, padding, mid-symbol digits,
//   dropped items after an error) are absorbed without touching the output.

module base64_stream_decoder_core
  import b64d_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // input items
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire logic [7:0]         char_in_i,
  input  wire logic               end_of_text_i,
  // result items
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      logic               byte_valid_o,
  output      logic [7:0]         data_byte_o,
  output      logic [2:0]         status_o,
  output      logic               done_res_o,
  // configuration
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output      logic [31:0]        prdata,
  output      logic               pready
);

  // Stream state
  logic [5:0] pend_bits_q, pend_bits_d;
  logic [2:0] pend_cnt_q, pend_cnt_d;
  logic [1:0] pad_cnt_q, pad_cnt_d;
  logic [2:0] err_q, err_d;
  logic       skip_ws_q;

  // Output register
  logic       out_valid_q;
  logic       byte_valid_q, byte_valid_d;
  logic [7:0] data_q, data_d;
  logic [2:0] status_q, status_d;
  logic       done_q, done_d;

  logic       in_fire;
  logic       emit;
  logic       have_byte;
  logic [7:0] byte_val;
  logic [6:0] sym;
  logic [11:0] acc;

  // Accept when the output register is empty or drains this cycle.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign sym = sym_value(char_in_i);
  assign acc = {pend_bits_q, sym[5:0]};

  // Decode step: padding check first, then symbol class, then accumulate.
  always_comb begin
    pend_bits_d = pend_bits_q;
    pend_cnt_d  = pend_cnt_q;
    pad_cnt_d   = pad_cnt_q;
    err_d       = err_q;
    have_byte   = 1'b0;
    byte_val    = 8'h00;
    if (err_q == ST_OK) begin
      if (char_in_i == CHAR_PAD) begin
        if (pad_cnt_q == 2'd3) begin
          err_d = ST_EXCESS_PAD;
        end else begin
          pad_cnt_d = pad_cnt_q + 2'd1;
        end
      end else if (pad_cnt_q != 2'd0) begin
        err_d = ST_DATA_AFTER_PAD;
      end else if (sym == SYM_INVALID) begin
        err_d = ST_INVALID;
      end else if (sym == SYM_SPACE) begin
        if (!skip_ws_q) begin
          err_d = ST_WHITESPACE;
        end
      end else begin
        // pending count is 0, 2, 4 or 6; adding six bits crosses a byte unless empty
        case (pend_cnt_q)
          3'd2: begin
            have_byte   = 1'b1;
            byte_val    = acc[7:0];
            pend_bits_d = 6'd0;
            pend_cnt_d  = 3'd0;
          end
          3'd4: begin
            have_byte   = 1'b1;
            byte_val    = acc[9:2];
            pend_bits_d = {4'd0, acc[1:0]};
            pend_cnt_d  = 3'd2;
          end
          3'd6: begin
            have_byte   = 1'b1;
            byte_val    = acc[11:4];
            pend_bits_d = {2'd0, acc[3:0]};
            pend_cnt_d  = 3'd4;
          end
          default: begin
            pend_bits_d = sym[5:0];
            pend_cnt_d  = 3'd6;
          end
        endcase
      end
    end
    // Last item: restart the stream after reporting.
    if (end_of_text_i) begin
      pend_bits_d = 6'd0;
      pend_cnt_d  = 3'd0;
      pad_cnt_d   = 2'd0;
      err_d       = ST_OK;
    end
  end

  // Status reported on the done item: the error left by this item, if any.
  function automatic logic [2:0] err_q_next_status();
    logic [2:0] s;
    s = ST_OK;
    if (err_q != ST_OK) begin
      s = err_q;
    end else if (char_in_i == CHAR_PAD) begin
      s = (pad_cnt_q == 2'd3) ? ST_EXCESS_PAD : ST_OK;
    end else if (pad_cnt_q != 2'd0) begin
      s = ST_DATA_AFTER_PAD;
    end else if (sym == SYM_INVALID) begin
      s = ST_INVALID;
    end else if (sym == SYM_SPACE && !skip_ws_q) begin
      s = ST_WHITESPACE;
    end
    return s;
  endfunction

  // Result formation
  always_comb begin
    emit         = have_byte || end_of_text_i;
    byte_valid_d = have_byte && (err_d == ST_OK || !end_of_text_i);
    done_d       = end_of_text_i;
    status_d     = end_of_text_i ? (have_byte ? ST_OK : err_q_next_status()) : ST_OK;
    data_d       = byte_valid_d ? byte_val : 8'h00;
  end

  // Stream state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_bits_q <= 6'd0;
      pend_cnt_q  <= 3'd0;
      pad_cnt_q   <= 2'd0;
      err_q       <= ST_OK;
    end else if (in_fire) begin
      pend_bits_q <= pend_bits_d;
      pend_cnt_q  <= pend_cnt_d;
      pad_cnt_q   <= pad_cnt_d;
      err_q       <= err_d;
    end
  end

  // Output register: load on a producing item, drop once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && emit) begin
      byte_valid_q <= byte_valid_d;
      data_q       <= data_d;
      status_q     <= status_d;
      done_q       <= done_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign byte_valid_o = byte_valid_q;
  assign data_byte_o  = data_q;
  assign status_o     = status_q;
  assign done_res_o   = done_q;

  // Configuration port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_ws_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr == REG_SKIP_WS) begin
      skip_ws_q <= pwdata[0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == REG_SKIP_WS) ? {31'd0, skip_ws_q} : 32'd0;

  // A delivered byte never rides with an error status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_valid_o |-> status_o == ST_OK)
    else $error("byte delivered with error status");

  // Only done items may lack a byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !done_res_o |-> byte_valid_o)
    else $error("non-done item without byte");

  // Last item leaves the stream state cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && end_of_text_i |=>
      pend_cnt_q == 3'd0 && pad_cnt_q == 2'd0 && err_q == ST_OK)
    else $error("stream state not cleared after last item");

  // Leftover bit count stays even and below eight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pend_cnt_q[0] && (pend_cnt_q != 3'd0 || pend_bits_q == 6'd0))
    else $error("bad accumulator state");

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the streaming Base64 decoder.
//
// An initial block builds text streams (directed first, then random ones that
// are mostly well-formed Base64 with random content, plus noise and broken
// streams) and loads them into a queue of pending items. A clocked driver
// feeds them into the input channel. At each accepted item, the decoder
// predictor runs and queues the results that item should cause. A clocked
// monitor takes results off the output channel and compares them with the
// oldest queued expectation. Between phases the bench drains the block and
// rewrites skip_whitespace over APB, then reads it back.

module testbench;
  import b64d_pkg::*;

  localparam int STALL_LIMIT = 2000;  // cycles with no handshake at all
  localparam int PHASE_ITEMS = 200;

  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
  } text_item_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] data_byte;
    logic [2:0] status;
    logic       done;
  } dec_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  char_in_i = 8'h00;
  logic        end_of_text_i = 1'b0;

  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        byte_valid_o;
  logic [7:0]  data_byte_o;
  logic [2:0]  status_o;
  logic        done_res_o;

  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = REG_SKIP_WS;
  logic [31:0]        pwdata = 32'h0;
  logic [31:0]        prdata;
  logic               pready;

  // Pending text items and expected results
  text_item_t  stim_q[$];
  dec_result_t exp_q[$];

  // Decoder predictor state
  logic       skip_ws_cfg = 1'b0;
  logic [5:0] held_bits = 6'h0;
  logic [2:0] held_cnt = 3'h0;
  logic [1:0] pad_seen = 2'h0;
  logic [2:0] stream_err = ST_OK;

  int err_count = 0;
  int idle_pct = 0;     // chance per slot of starting an idle burst
  int tx_gap = 0;
  int rx_gap = 0;
  int stall_cycles = 0;
  text_item_t  next_item;
  dec_result_t got, want;

  base64_stream_decoder_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .char_in_i     (char_in_i),
    .end_of_text_i (end_of_text_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .byte_valid_o  (byte_valid_o),
    .data_byte_o   (data_byte_o),
    .status_o      (status_o),
    .done_res_o    (done_res_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #4 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    err_count++;
    $display("ERROR %0t: %s", $time, msg);
  endtask

  // Digit value of a text character, or a symbol class for blanks and junk.
  function automatic logic [6:0] char_class(input logic [7:0] c);
    logic [6:0] v;
    v = SYM_INVALID;
    if (c >= 8'h41 && c <= 8'h5A) begin
      v = 7'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      v = 7'(c - 8'h47);        // 'a' lands on 26
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v = 7'(c + 8'h04);        // '0' lands on 52
    end else if (c == 8'h2B || c == 8'h2D) begin
      v = 7'd62;
    end else if (c == 8'h2F || c == 8'h5F) begin
      v = 7'd63;
    end else if (c == 8'h20 || c == 8'h0D || c == 8'h09 || c == 8'h0A) begin
      v = SYM_SPACE;
    end
    return v;
  endfunction

  function automatic logic [7:0] sextet_char(input logic [5:0] v, input logic url);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + 8'(v);
    end else if (v < 6'd52) begin
      c = 8'h47 + 8'(v);
    end else if (v < 6'd62) begin
      c = 8'(v) - 8'h04;
    end else if (v == 6'd62) begin
      c = url ? 8'h2D : 8'h2B;
    end else begin
      c = url ? 8'h5F : 8'h2F;
    end
    return c;
  endfunction

  function automatic logic [7:0] blank_char();
    logic [7:0] c;
    case ($urandom_range(0, 3))
      0: c = 8'h20;
      1: c = 8'h0D;
      2: c = 8'h09;
      default: c = 8'h0A;
    endcase
    return c;
  endfunction

  // Advance the decoder predictor by one accepted item and queue its result.
  task automatic decode_step(input logic [7:0] c, input logic last);
    logic [6:0]  sym;
    logic [11:0] acc;
    int          cnt;
    logic        have_byte;
    logic [7:0]  dec_byte;
    dec_result_t r;
    have_byte = 1'b0;
    dec_byte = 8'h00;
    // after the first error, drop everything up to the end of the text
    if (stream_err == ST_OK) begin
      if (c == CHAR_PAD) begin
        if (pad_seen == 2'd3) begin
          stream_err = ST_EXCESS_PAD;
        end else begin
          pad_seen = pad_seen + 2'd1;
        end
      end else if (pad_seen != 2'd0) begin
        // padding check wins over whitespace and junk
        stream_err = ST_DATA_AFTER_PAD;
      end else begin
        sym = char_class(c);
        if (sym == SYM_INVALID) begin
          stream_err = ST_INVALID;
        end else if (sym == SYM_SPACE) begin
          if (!skip_ws_cfg) begin
            stream_err = ST_WHITESPACE;
          end
        end else begin
          acc = {held_bits, sym[5:0]};
          cnt = held_cnt + 6;
          if (cnt >= 8) begin
            cnt = cnt - 8;
            dec_byte = 8'(acc >> cnt);
            have_byte = 1'b1;
          end
          held_bits = 6'(acc & ((12'd1 << cnt) - 12'd1));
          held_cnt = 3'(cnt);
        end
      end
    end

    if (last) begin
      // the done item carries the status; leftover bits are dropped
      r.byte_valid = have_byte && (stream_err == ST_OK);
      r.data_byte = r.byte_valid ? dec_byte : 8'h00;
      r.status = stream_err;
      r.done = 1'b1;
      exp_q.push_back(r);
      held_bits = 6'h0;
      held_cnt = 3'h0;
      pad_seen = 2'h0;
      stream_err = ST_OK;
    end else if (have_byte) begin
      r = {1'b1, dec_byte, ST_OK, 1'b0};
      exp_q.push_back(r);
    end
  endtask

  task automatic push_item(input logic [7:0] c, input logic eot);
    stim_q.push_back(text_item_t'{c, eot});
  endtask

  // Queue one stream; the last character carries end_of_text.
  task automatic push_text(input string t);
    for (int i = 0; i < t.len(); i++) begin
      push_item(t[i], i == t.len() - 1);
    end
  endtask

  // Build one random stream: mostly valid Base64 with random bytes, some
  // broken ones, some pure noise.
  task automatic gen_stream(input logic ws_ok, output int count);
    text_item_t  s[$];
    logic [23:0] grp;
    logic        url;
    int          kind, nb, nsx, pos;
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      repeat ($urandom_range(1, 6)) s.push_back(text_item_t'{8'($urandom), 1'b0});
    end else begin
      // mostly short texts, now and then a long one
      nb = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 48) : $urandom_range(1, 8);
      url = 1'($urandom_range(0, 1));
      for (int i = 0; i < nb; i += 3) begin
        grp = 24'($urandom);
        nsx = (nb - i >= 3) ? 4 : nb - i + 1;
        for (int j = 0; j < nsx; j++) begin
          // blanks are rare where they are an error
          if ($urandom_range(0, ws_ok ? 5 : 60) == 0) begin
            s.push_back(text_item_t'{blank_char(), 1'b0});
          end
          s.push_back(text_item_t'{sextet_char(grp[23 - 6*j -: 6], url), 1'b0});
        end
        if (nsx < 4 && $urandom_range(0, 3) != 0) begin
          repeat (4 - nsx) s.push_back(text_item_t'{CHAR_PAD, 1'b0});
        end
      end
      if (kind < 25) begin
        // corrupt one position
        pos = $urandom_range(0, s.size() - 1);
        s[pos].ch = $urandom_range(0, 1) ? CHAR_PAD : 8'($urandom);
      end else if (kind < 30) begin
        repeat ($urandom_range(1, 4)) s.push_back(text_item_t'{CHAR_PAD, 1'b0});
      end else if (ws_ok && kind < 40) begin
        s.push_back(text_item_t'{blank_char(), 1'b0});
      end
    end
    s[s.size() - 1].eot = 1'b1;
    count = s.size();
    for (int k = 0; k < s.size(); k++) begin
      stim_q.push_back(s[k]);
    end
  endtask

  // One APB transfer: setup cycle, then access until pready.
  task automatic apb_xfer(input logic wr, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= REG_SKIP_WS;
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Write skip_whitespace (junk in the upper bits) and read it back.
  task automatic set_skip_ws(input logic val);
    logic [31:0] rd;
    apb_xfer(1'b1, {31'($urandom), val}, rd);
    skip_ws_cfg = val;
    apb_xfer(1'b0, 32'h0, rd);
    if (rd !== {31'h0, val}) begin
      report_mismatch($sformatf("skip_whitespace reads %08h, wrote %0b", rd, val));
    end
  endtask

  // Hold until every queued item is taken and every result has come back,
  // then let the block settle after items that cause no result.
  task automatic drain();
    do @(negedge clk_i); while (stim_q.size() != 0 || in_valid_i || exp_q.size() != 0);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Driver: predict at acceptance, then load the next item or idle.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        decode_step(char_in_i, end_of_text_i);
      end
      if (!in_valid_i || in_ready_o) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid_i <= 1'b0;
        end else if ($urandom_range(0, 99) < idle_pct) begin
          tx_gap = $urandom_range(0, 3);
          in_valid_i <= 1'b0;
        end else if (stim_q.size() != 0) begin
          next_item = stim_q.pop_front();
          in_valid_i <= 1'b1;
          char_in_i <= next_item.ch;
          end_of_text_i <= next_item.eot;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result, and stall the output in bursts.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got = {byte_valid_o, data_byte_o, status_o, done_res_o};
        if (exp_q.size() == 0) begin
          report_mismatch($sformatf("unexpected item bv=%0b byte=%02h st=%0d done=%0b",
                                    got.byte_valid, got.data_byte, got.status, got.done));
        end else begin
          want = exp_q.pop_front();
          if (got.byte_valid !== want.byte_valid || got.data_byte !== want.data_byte ||
              got.status !== want.status || got.done !== want.done) begin
            report_mismatch($sformatf(
              "got bv=%0b byte=%02h st=%0d done=%0b, want bv=%0b byte=%02h st=%0d done=%0b",
              got.byte_valid, got.data_byte, got.status, got.done,
              want.byte_valid, want.data_byte, want.status, want.done));
          end
        end
      end
      if (rx_gap > 0) begin
        rx_gap--;
        out_ready_i <= 1'b0;
      end else if ($urandom_range(0, 99) < idle_pct) begin
        rx_gap = $urandom_range(0, 3);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog: drop the run if no handshake happens for too long.
  always @(posedge clk_i) begin
    if (rst_ni && !(in_valid_i && in_ready_o) && !(out_valid_o && out_ready_i)) begin
      stall_cycles++;
    end else begin
      stall_cycles = 0;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    logic [31:0] rd;
    int          n, cnt;
    logic        skip_seq[6];
    skip_seq = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // register must come out of reset cleared
    apb_xfer(1'b0, 32'h0, rd);
    if (rd !== 32'h0) begin
      report_mismatch($sformatf("skip_whitespace reads %08h after reset", rd));
    end

    // Directed streams, whitespace flagged as an error
    idle_pct = 20;
    @(negedge clk_i);
    push_text("TWFu");          // last item completes a byte
    push_text("-_+/");          // both alphabets for 62 and 63
    push_text("AA==");          // padding, leftover bits dropped
    push_text("====");          // fourth pad character
    push_text("A=B");           // data after padding
    push_item(8'h54, 1'b0);     // error mid-stream: later items ignored,
    push_item(8'h57, 1'b0);     // the byte already out stays out
    push_item(8'h00, 1'b0);
    push_item(8'h75, 1'b1);
    push_item(8'hFF, 1'b1);     // top code, invalid
    push_item(8'h20, 1'b1);     // blank not allowed
    drain();

    // Random phases, each under its own skip setting
    for (int ph = 0; ph < 6; ph++) begin
      set_skip_ws(skip_seq[ph]);
      case (ph)
        1: idle_pct = 0;
        5: idle_pct = 0;          // no idling at the tail of the run
        default: idle_pct = 15 + 10 * (ph % 2);
      endcase
      @(negedge clk_i);
      n = 0;
      while (n < PHASE_ITEMS) begin
        gen_stream(skip_ws_cfg, cnt);
        n += cnt;
        // hold the sender once until every result is back
        if (ph == 2 && n >= PHASE_ITEMS / 2 && n - cnt < PHASE_ITEMS / 2) begin
          drain();
        end
      end
      drain();
    end

    repeat (8) @(posedge clk_i);
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
